FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared helpers for clocked assertions with a synchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define GPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same-cycle implication.
`define GPA_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    `GPA_ASSERT(label, clk, rst_n, (ante) |-> (cons), msg)

`endif

FILE: sv/gpa_pkg.sv
// ----------------------------------------------------------------------------
// Gaussian principal axes package
// Item types, fixed-point constants and the exp ROM generator.
// ----------------------------------------------------------------------------
package gpa_pkg;

    localparam int FRAC_BITS = 30;
    localparam int DIV_BITS  = 15;

    localparam logic [28:0] LOG2E_Q28 = 29'd387270502;
    localparam logic [15:0] ONE_Q14   = 16'd16384;

    localparam logic [1:0] AXIS_A = 2'd0;
    localparam logic [1:0] AXIS_B = 2'd1;
    localparam logic [1:0] AXIS_C = 2'd2;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] log_scale_a;
        logic signed [15:0] log_scale_b;
        logic signed [15:0] log_scale_c;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         axis_number;
        logic signed [15:0] dir_x;
        logic signed [15:0] dir_y;
        logic signed [15:0] dir_z;
        logic [31:0]        axis_length;
        logic               is_longest;
        logic               last_axis;
    } t_out_item;

    // One axis of one item, as handed from the front end to the pipeline.
    typedef struct packed {
        logic [1:0]         axis;
        logic signed [15:0] qw;
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] lscale;
    } t_beat;

    typedef struct packed {
        logic [1:0]  axis;
        logic [15:0] dir_x;
        logic [15:0] dir_y;
        logic [15:0] dir_z;
        logic [31:0] len;
    } t_res;

    // Truncating integer square root, one result bit per iteration.
    function automatic logic [63:0] f_isqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bit_v;
        logic [63:0] rem;
        res   = '0;
        bit_v = 64'h4000_0000_0000_0000;
        rem   = v;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bit_v) begin
                rem = rem - (res + bit_v);
                res = (res >> 1) + bit_v;
            end else begin
                res = res >> 1;
            end
            bit_v = bit_v >> 2;
        end
        return res;
    endfunction

    // Factor 2^(2^-j) in Q30; each entry is the square root of the one before.
    function automatic logic [FRAC_BITS:0] f_exp_rom(input int j);
        logic [63:0] v;
        v = f_isqrt(64'd2 << 60);
        for (int i = 1; i < j; i++) begin
            v = f_isqrt({v[63-FRAC_BITS:0], {FRAC_BITS{1'b0}}});
        end
        return v[FRAC_BITS:0];
    endfunction

endpackage

FILE: sv/gaussian_principal_axes_core.sv
// ----------------------------------------------------------------------------
// Gaussian principal axes core
// Splat quaternion and log-scales in, one result per principal axis out.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / i_in / o_in_stall carries one splat item, a raw
// quaternion and three log-scales in signed Q4.12. An item is taken on a
// clock edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / o_out / i_out_stall carries three results per
// item, axis 0, 1, 2 in order; last_axis marks the third and is_longest the
// longest axis (lowest axis wins a tie).
// Results of an item leave one per cycle while i_out_stall is low. The front
// end issues one axis per cycle, while the pipeline advances, into a 34-stage
// pipeline, and takes a new item as it issues the last axis of the one before.
// The 30 exp ROM multiplies set the pipeline depth; the 15-step divider runs
// alongside them.
// Reset (i_rst_n low at a clock edge) empties every stage; no result is kept.
// While i_out_stall is high the current result holds; once the gather is full
// and the last stage holds a result, the pipe freezes and o_in_stall rises.
// ----------------------------------------------------------------------------
module gaussian_principal_axes_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  gpa_pkg::t_in_item  i_in,
    output logic               o_in_stall,
    output logic               o_out_valid,
    output gpa_pkg::t_out_item o_out,
    input  logic               i_out_stall
);

    logic           beat_valid;
    gpa_pkg::t_beat beat;
    logic           beat_ready;
    logic           res_valid;
    gpa_pkg::t_res  res;
    logic           res_ready;

    gpa_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in         (i_in),
        .o_in_stall   (o_in_stall),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .i_beat_ready (beat_ready)
    );

    gpa_pipe u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (beat_valid),
        .i_beat       (beat),
        .o_beat_ready (beat_ready),
        .o_res_valid  (res_valid),
        .o_res        (res),
        .i_res_ready  (res_ready)
    );

    gpa_gather u_gather (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (res),
        .o_res_ready (res_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: sv/gpa_front.sv
// ----------------------------------------------------------------------------
// Front end
// Holds one input item and hands its three axes to the pipeline in order.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpa_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  gpa_pkg::t_in_item i_in,
    output logic              o_in_stall,
    output logic              o_beat_valid,
    output gpa_pkg::t_beat    o_beat,
    input  logic              i_beat_ready
);

    gpa_pkg::t_in_item r_item;
    logic              r_iv;
    logic [1:0]        r_bidx;

    logic beat_take;
    logic beat_last;
    logic in_take;

    assign beat_take  = r_iv && i_beat_ready;
    assign beat_last  = (r_bidx == gpa_pkg::AXIS_C);
    assign o_in_stall = r_iv && !(beat_take && beat_last);
    assign in_take    = i_in_valid && !o_in_stall;

    assign o_beat_valid = r_iv;

    always_comb begin
        o_beat.axis = r_bidx;
        o_beat.qw   = r_item.quat_w;
        o_beat.qx   = r_item.quat_x;
        o_beat.qy   = r_item.quat_y;
        o_beat.qz   = r_item.quat_z;
        case (r_bidx)
            gpa_pkg::AXIS_A: o_beat.lscale = r_item.log_scale_a;
            gpa_pkg::AXIS_B: o_beat.lscale = r_item.log_scale_b;
            default:         o_beat.lscale = r_item.log_scale_c;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_bidx <= gpa_pkg::AXIS_A;
        end else begin
            if (in_take) begin
                r_iv   <= 1'b1;
                r_bidx <= gpa_pkg::AXIS_A;
            end else if (beat_take) begin
                if (beat_last) begin
                    r_iv <= 1'b0;
                end else begin
                    r_bidx <= r_bidx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item <= i_in;
        end
    end

    `GPA_ASSERT(a_front_drain, i_clk, i_rst_n, (beat_take && beat_last && !i_in_valid) |=> !r_iv, "front: item not released after last axis")
    `GPA_ASSERT_IMPL(a_front_idx, i_clk, i_rst_n, r_iv, r_bidx != 2'd3, "front: axis index out of range")
    `GPA_ASSERT(a_front_step, i_clk, i_rst_n, (beat_take && !beat_last) |=> (r_iv && r_bidx == $past(r_bidx) + 2'd1), "front: axis index did not advance")

endmodule

FILE: sv/gpa_pipe.sv
// ----------------------------------------------------------------------------
// Axis pipeline
// Per axis: quaternion products, matrix column by restoring division and
// axis length by a chain of ROM multiplies, one register stage per step.
// ----------------------------------------------------------------------------
module gpa_pipe (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_beat_valid,
    input  gpa_pkg::t_beat i_beat,
    output logic           o_beat_ready,
    output logic           o_res_valid,
    output gpa_pkg::t_res  o_res,
    input  logic           i_res_ready
);

    localparam int NumSteps = gpa_pkg::FRAC_BITS;
    localparam int DivBits  = gpa_pkg::DIV_BITS;

    typedef struct packed {
        logic [1:0]         axis;
        logic signed [31:0] ww;
        logic signed [31:0] xx;
        logic signed [31:0] yy;
        logic signed [31:0] zz;
        logic signed [31:0] xy;
        logic signed [31:0] wz;
        logic signed [31:0] xz;
        logic signed [31:0] wy;
        logic signed [31:0] yz;
        logic signed [31:0] wx;
        logic signed [45:0] m;
    } t_prod;

    typedef struct packed {
        logic [1:0]                  axis;
        logic [32:0]                 n;
        logic [2:0]                  neg;
        logic [2:0][32:0]            rem;
        logic [2:0][DivBits-1:0]     dlow;
        logic [2:0][DivBits-1:0]     q;
        logic signed [5:0]           k;
        logic [NumSteps-1:0]         f;
        logic [NumSteps:0]           acc;
    } t_stage;

    typedef struct packed {
        logic [1:0]       axis;
        logic [2:0][15:0] dir;
        logic [32:0]      v3;
        logic [5:0]       sh;
    } t_fin;

    logic adv;

    t_prod  r_p, n_p;
    logic   r_pv;
    t_stage r_b [0:NumSteps];
    t_stage n_b0;
    t_stage n_b [1:NumSteps];
    logic [NumSteps:0] r_bv;
    t_fin   r_f1, n_f1;
    logic   r_f1v;
    gpa_pkg::t_res r_f2, n_f2;
    logic   r_f2v;

    // The whole pipe moves together; it holds only when the last stage is stalled.
    assign adv          = !r_f2v || i_res_ready;
    assign o_beat_ready = adv;
    assign o_res_valid  = r_f2v;
    assign o_res        = r_f2;

    // Products stage.
    always_comb begin
        n_p.axis = i_beat.axis;
        n_p.ww   = 32'(i_beat.qw * i_beat.qw);
        n_p.xx   = 32'(i_beat.qx * i_beat.qx);
        n_p.yy   = 32'(i_beat.qy * i_beat.qy);
        n_p.zz   = 32'(i_beat.qz * i_beat.qz);
        n_p.xy   = 32'(i_beat.qx * i_beat.qy);
        n_p.wz   = 32'(i_beat.qw * i_beat.qz);
        n_p.xz   = 32'(i_beat.qx * i_beat.qz);
        n_p.wy   = 32'(i_beat.qw * i_beat.qy);
        n_p.yz   = 32'(i_beat.qy * i_beat.qz);
        n_p.wx   = 32'(i_beat.qw * i_beat.qx);
        n_p.m    = 46'(i_beat.lscale * $signed({1'b0, gpa_pkg::LOG2E_Q28}));
    end

    // Numerators, norm and divider setup; exponent split into k and fraction.
    logic signed [34:0] sww, sxx, syy, szz, sxy, swz, sxz, swy, syz, swx;
    logic signed [2:0][34:0] num;
    logic [2:0][32:0] mag;
    logic [2:0][46:0] dvd;

    always_comb begin
        sww = 35'(r_p.ww);
        sxx = 35'(r_p.xx);
        syy = 35'(r_p.yy);
        szz = 35'(r_p.zz);
        sxy = 35'(r_p.xy);
        swz = 35'(r_p.wz);
        sxz = 35'(r_p.xz);
        swy = 35'(r_p.wy);
        syz = 35'(r_p.yz);
        swx = 35'(r_p.wx);
        case (r_p.axis)
            gpa_pkg::AXIS_A: begin
                num[0] = sww + sxx - syy - szz;
                num[1] = (sxy + swz) <<< 1;
                num[2] = (sxz - swy) <<< 1;
            end
            gpa_pkg::AXIS_B: begin
                num[0] = (sxy - swz) <<< 1;
                num[1] = sww - sxx + syy - szz;
                num[2] = (syz + swx) <<< 1;
            end
            default: begin
                num[0] = (sxz + swy) <<< 1;
                num[1] = (syz - swx) <<< 1;
                num[2] = sww - sxx - syy + szz;
            end
        endcase

        n_b0.axis = r_p.axis;
        n_b0.n    = 33'(r_p.ww) + 33'(r_p.xx) + 33'(r_p.yy) + 33'(r_p.zz);
        for (int r = 0; r < 3; r++) begin
            n_b0.neg[r]  = num[r][34];
            mag[r]       = num[r][34] ? 33'(-num[r]) : num[r][32:0];
            // Dividend carries the rounding half of the divisor.
            dvd[r]       = {mag[r], 14'd0} + 47'(n_b0.n[32:1]);
            n_b0.rem[r]  = {1'b0, dvd[r][46:DivBits]};
            n_b0.dlow[r] = dvd[r][DivBits-1:0];
            n_b0.q[r]    = '0;
        end
        n_b0.k   = r_p.m[45:40];
        n_b0.f   = r_p.m[39:40-NumSteps];
        n_b0.acc = (NumSteps+1)'(1) << NumSteps;
    end

    for (genvar s = 1; s <= NumSteps; s++) begin : g_step
        localparam logic [NumSteps:0] RomVal = gpa_pkg::f_exp_rom(s);
        t_stage nx;
        logic [2*NumSteps+1:0] prod;
        logic [2:0][33:0] trial;

        always_comb begin
            nx    = r_b[s-1];
            trial = '0;
            prod  = (2*NumSteps+2)'(nx.acc) * (2*NumSteps+2)'(RomVal)
                    + ((2*NumSteps+2)'(1) << (NumSteps - 1));
            if (nx.f[NumSteps - s]) begin
                nx.acc = prod[2*NumSteps:NumSteps];
            end
            if (s <= DivBits) begin
                for (int r = 0; r < 3; r++) begin
                    trial[r] = {nx.rem[r], nx.dlow[r][DivBits-1]};
                    if (trial[r] >= {1'b0, nx.n}) begin
                        nx.rem[r] = 33'(trial[r] - {1'b0, nx.n});
                        nx.q[r]   = {nx.q[r][DivBits-2:0], 1'b1};
                    end else begin
                        nx.rem[r] = trial[r][32:0];
                        nx.q[r]   = {nx.q[r][DivBits-2:0], 1'b0};
                    end
                    nx.dlow[r] = {nx.dlow[r][DivBits-2:0], 1'b0};
                end
            end
        end

        assign n_b[s] = nx;
    end

    // Sign and zero-norm fixup; length times three and shift amount.
    always_comb begin
        n_f1.axis = r_b[NumSteps].axis;
        for (int r = 0; r < 3; r++) begin
            if (r_b[NumSteps].n == '0) begin
                n_f1.dir[r] = (2'(r) == r_b[NumSteps].axis) ? gpa_pkg::ONE_Q14 : 16'd0;
            end else if (r_b[NumSteps].neg[r]) begin
                n_f1.dir[r] = 16'(-{1'b0, r_b[NumSteps].q[r]});
            end else begin
                n_f1.dir[r] = {1'b0, r_b[NumSteps].q[r]};
            end
        end
        n_f1.v3 = 33'(r_b[NumSteps].acc) * 33'd3;
        n_f1.sh = 6'd14 - 6'(r_b[NumSteps].k);
    end

    logic [33:0] rnd_sum;

    always_comb begin
        rnd_sum      = {1'b0, r_f1.v3} + (34'd1 << (r_f1.sh - 6'd1));
        n_f2.axis    = r_f1.axis;
        n_f2.dir_x   = r_f1.dir[0];
        n_f2.dir_y   = r_f1.dir[1];
        n_f2.dir_z   = r_f1.dir[2];
        n_f2.len     = 32'(rnd_sum >> r_f1.sh);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_bv  <= '0;
            r_f1v <= 1'b0;
            r_f2v <= 1'b0;
        end else if (adv) begin
            r_pv  <= i_beat_valid;
            r_bv  <= {r_bv[NumSteps-1:0], r_pv};
            r_f1v <= r_bv[NumSteps];
            r_f2v <= r_f1v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p    <= n_p;
            r_b[0] <= n_b0;
            for (int s = 1; s <= NumSteps; s++) begin
                r_b[s] <= n_b[s];
            end
            r_f1   <= n_f1;
            r_f2   <= n_f2;
        end
    end

endmodule

FILE: sv/gpa_gather.sv
// ----------------------------------------------------------------------------
// Result gather
// Collects the three axes of an item, picks the longest and sends them out.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gpa_gather (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_res_valid,
    input  gpa_pkg::t_res      i_res,
    output logic               o_res_ready,
    output logic               o_out_valid,
    output gpa_pkg::t_out_item o_out,
    input  logic               i_out_stall
);

    gpa_pkg::t_res r_g [0:2];
    logic [1:0]    r_gcnt;
    gpa_pkg::t_res r_e [0:2];
    logic          r_ev;
    logic [1:0]    r_idx;
    logic [1:0]    r_best;

    logic       xfer;
    logic       take;
    logic [1:0] slot;
    logic [1:0] n_best;
    logic [31:0] best_len;

    // The slots go to the send buffer when it is empty or as its last axis leaves.
    assign xfer = (r_gcnt == 2'd3)
                  && (!r_ev || (r_idx == gpa_pkg::AXIS_C && !i_out_stall));
    assign o_res_ready = (r_gcnt != 2'd3) || xfer;
    assign take        = i_res_valid && o_res_ready;
    assign slot        = xfer ? gpa_pkg::AXIS_A : r_gcnt;

    always_comb begin
        n_best   = (r_g[1].len > r_g[0].len) ? gpa_pkg::AXIS_B : gpa_pkg::AXIS_A;
        best_len = (n_best == gpa_pkg::AXIS_B) ? r_g[1].len : r_g[0].len;
        if (r_g[2].len > best_len) begin
            n_best = gpa_pkg::AXIS_C;
        end
    end

    assign o_out_valid       = r_ev;
    assign o_out.axis_number = r_e[r_idx].axis;
    assign o_out.dir_x       = r_e[r_idx].dir_x;
    assign o_out.dir_y       = r_e[r_idx].dir_y;
    assign o_out.dir_z       = r_e[r_idx].dir_z;
    assign o_out.axis_length = r_e[r_idx].len;
    assign o_out.is_longest  = (r_idx == r_best);
    assign o_out.last_axis   = (r_idx == gpa_pkg::AXIS_C);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gcnt <= 2'd0;
            r_ev   <= 1'b0;
            r_idx  <= gpa_pkg::AXIS_A;
        end else begin
            if (xfer && take) begin
                r_gcnt <= 2'd1;
            end else if (xfer) begin
                r_gcnt <= 2'd0;
            end else if (take) begin
                r_gcnt <= r_gcnt + 2'd1;
            end

            if (xfer) begin
                r_ev  <= 1'b1;
                r_idx <= gpa_pkg::AXIS_A;
            end else if (r_ev && !i_out_stall) begin
                if (r_idx == gpa_pkg::AXIS_C) begin
                    r_ev <= 1'b0;
                end else begin
                    r_idx <= r_idx + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_g[slot] <= i_res;
        end
        if (xfer) begin
            r_e[0] <= r_g[0];
            r_e[1] <= r_g[1];
            r_e[2] <= r_g[2];
            r_best <= n_best;
        end
    end

    `GPA_ASSERT(a_xfer_load, i_clk, i_rst_n, xfer |=> (r_ev && r_idx == gpa_pkg::AXIS_A), "gather: send buffer not loaded")
    `GPA_ASSERT_IMPL(a_axis_order, i_clk, i_rst_n, r_ev, r_e[r_idx].axis == r_idx, "gather: axis out of order")
    `GPA_ASSERT(a_idx_hold, i_clk, i_rst_n, (r_ev && i_out_stall) |=> (r_ev && r_idx == $past(r_idx)), "gather: axis moved while stalled")

endmodule

FILE: dv/gaussian_principal_axes_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Gaussian principal axes core testbench
// Drives splat items with random gaps and output stalls, predicts the three
// axis results of each item in fixed point and checks them in order.
// ----------------------------------------------------------------------------
module gaussian_principal_axes_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 60;

    class axis_scoreboard;
        gpa_pkg::t_out_item expected_axes[$];
        longint unsigned exp2_rom[31];
        int fails;

        function new();
            fails = 0;
            exp2_rom[1] = root_floor(64'd2 << 60);
            for (int j = 1; j < 30; j++) begin
                exp2_rom[j + 1] = root_floor(exp2_rom[j] << 30);
            end
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned r;
            longint unsigned b;
            r = 0;
            b = 64'h4000_0000_0000_0000;
            while (b > v) b = b >> 2;
            while (b != 0) begin
                if (v >= r + b) begin
                    v = v - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            return r;
        endfunction

        // Rounds num/den to Q2.14, halves away from zero, then clamps.
        function logic [15:0] dir_q14(longint num, longint unsigned den);
            longint unsigned mag;
            longint unsigned q;
            mag = (num < 0) ? longint'(-num) : longint'(num);
            q = ((mag << 14) + den / 2) / den;
            if (num < 0) return (q > 32768) ? 16'h8000 : 16'(-longint'(q));
            return (q > 32767) ? 16'h7fff : 16'(q);
        endfunction

        // 3 * exp(t) as 3 * 2^(t*log2(e)), split into integer and fraction.
        function logic [31:0] length_q16(logic signed [15:0] t);
            longint m;
            longint k;
            longint unsigned f30;
            longint unsigned acc;
            longint unsigned v;
            int sh;
            m = longint'(t) * longint'(gpa_pkg::LOG2E_Q28);
            k = m >>> 40;
            f30 = longint'(m - (k <<< 40)) >> 10;
            acc = 64'd1 << 30;
            for (int j = 1; j <= 30; j++) begin
                if ((f30 >> (30 - j)) & 1) acc = (acc * exp2_rom[j] + (64'd1 << 29)) >> 30;
            end
            v = 3 * acc;
            sh = 14 - int'(k);
            if (sh > 0) begin
                if (sh > 63) return 32'd0;
                v = (v + (64'd1 << (sh - 1))) >> sh;
            end else if (sh < 0) begin
                if (-sh > 30 || v > (64'hffff_ffff >> (-sh))) return 32'hffff_ffff;
                v = v << (-sh);
            end
            return (v > 64'hffff_ffff) ? 32'hffff_ffff : v[31:0];
        endfunction

        function void note_splat(gpa_pkg::t_in_item s);
            longint w, x, y, z, ww, xx, yy, zz;
            longint unsigned n;
            longint num[3][3];
            logic [31:0] len[3];
            int best;
            gpa_pkg::t_out_item r;
            w = s.quat_w; x = s.quat_x; y = s.quat_y; z = s.quat_z;
            ww = w * w; xx = x * x; yy = y * y; zz = z * z;
            n = ww + xx + yy + zz;
            num[0][0] = ww + xx - yy - zz;
            num[0][1] = 2 * (x * y + w * z);
            num[0][2] = 2 * (x * z - w * y);
            num[1][0] = 2 * (x * y - w * z);
            num[1][1] = ww - xx + yy - zz;
            num[1][2] = 2 * (y * z + w * x);
            num[2][0] = 2 * (x * z + w * y);
            num[2][1] = 2 * (y * z - w * x);
            num[2][2] = ww - xx - yy + zz;
            len[0] = length_q16(s.log_scale_a);
            len[1] = length_q16(s.log_scale_b);
            len[2] = length_q16(s.log_scale_c);
            best = 0;
            for (int a = 1; a < 3; a++) if (len[a] > len[best]) best = a;
            for (int a = 0; a < 3; a++) begin
                r.axis_number = 2'(a);
                if (n == 0) begin
                    // A zero quaternion leaves the identity matrix.
                    r.dir_x = (a == 0) ? gpa_pkg::ONE_Q14 : 16'd0;
                    r.dir_y = (a == 1) ? gpa_pkg::ONE_Q14 : 16'd0;
                    r.dir_z = (a == 2) ? gpa_pkg::ONE_Q14 : 16'd0;
                end else begin
                    r.dir_x = dir_q14(num[a][0], n);
                    r.dir_y = dir_q14(num[a][1], n);
                    r.dir_z = dir_q14(num[a][2], n);
                end
                r.axis_length = len[a];
                r.is_longest = (a == best);
                r.last_axis = (r.axis_number == gpa_pkg::AXIS_C);
                expected_axes.push_back(r);
            end
        endfunction

        task report(string what, longint got, longint want);
            $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
            fails++;
        endtask

        task check_axis(gpa_pkg::t_out_item got);
            gpa_pkg::t_out_item want;
            if (expected_axes.size() == 0) begin
                report("unexpected result, axis", got.axis_number, -1);
                return;
            end
            want = expected_axes.pop_front();
            if (got.axis_number !== want.axis_number)
                report("axis_number", got.axis_number, want.axis_number);
            if (got.dir_x !== want.dir_x) report("dir_x", got.dir_x, want.dir_x);
            if (got.dir_y !== want.dir_y) report("dir_y", got.dir_y, want.dir_y);
            if (got.dir_z !== want.dir_z) report("dir_z", got.dir_z, want.dir_z);
            if (got.axis_length !== want.axis_length)
                report("axis_length", got.axis_length, want.axis_length);
            if (got.is_longest !== want.is_longest)
                report("is_longest", got.is_longest, want.is_longest);
            if (got.last_axis !== want.last_axis)
                report("last_axis", got.last_axis, want.last_axis);
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    gpa_pkg::t_in_item i_in;
    logic o_in_stall;
    logic o_out_valid;
    gpa_pkg::t_out_item o_out;
    logic i_out_stall;

    axis_scoreboard sb;
    int cycle_count = 0;
    int results_seen = 0;
    bit calm_sender;
    bit calm_receiver;

    gaussian_principal_axes_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .i_in(i_in),
        .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid),
        .o_out(o_out),
        .i_out_stall(i_out_stall)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("gaussian_principal_axes_core_tb: FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_quat_part();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) return 16'($signed($urandom_range(0, 16384)) - 8192);
        if (mode < 8) return 16'($urandom);
        return 16'($signed($urandom_range(0, 6)) - 3);
    endfunction

    function automatic logic [15:0] pick_log_scale();
        if ($urandom_range(0, 9) < 7) return 16'($signed($urandom_range(0, 32768)) - 16384);
        return 16'($urandom);
    endfunction

    function automatic gpa_pkg::t_in_item random_splat();
        gpa_pkg::t_in_item s;
        s.quat_w = pick_quat_part();
        s.quat_x = pick_quat_part();
        s.quat_y = pick_quat_part();
        s.quat_z = pick_quat_part();
        s.log_scale_a = pick_log_scale();
        s.log_scale_b = pick_log_scale();
        s.log_scale_c = pick_log_scale();
        // Now and then equal scales, to exercise the tie rule.
        if ($urandom_range(0, 9) == 0) s.log_scale_c = s.log_scale_a;
        if ($urandom_range(0, 9) == 0) s.log_scale_b = s.log_scale_c;
        return s;
    endfunction

    task automatic drive_splat(gpa_pkg::t_in_item s);
        int gap;
        gap = calm_sender ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            @(negedge i_clk) i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in <= s;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_splat(s);
    endtask

    task automatic drive_directed(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                                  logic [15:0] z, logic [15:0] la, logic [15:0] lb,
                                  logic [15:0] lc);
        gpa_pkg::t_in_item s;
        s = '{w, x, y, z, la, lb, lc};
        drive_splat(s);
    endtask

    // Result side: random stall per result, one long hold to fill the pipeline.
    initial begin
        int hold;
        bit long_done;
        hold = 0;
        long_done = 0;
        @(posedge i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !i_out_stall) begin
                sb.check_axis(o_out);
                results_seen++;
                if (results_seen == 150 && !long_done) begin
                    hold = 300;
                    long_done = 1;
                end else if (hold == 0) begin
                    hold = calm_receiver ? 0 : $urandom_range(0, 16);
                end
            end
            @(negedge i_clk);
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        sb = new();
        calm_sender = 0;
        calm_receiver = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in = '0;
        i_out_stall = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        // Zero quaternion, identity, extremes of every field, ties.
        drive_directed(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        drive_directed(16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'hf000);
        drive_directed(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        drive_directed(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        drive_directed(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h0000);
        drive_directed(16'h0000, 16'h1000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h7fff);
        drive_directed(16'h0000, 16'h0000, 16'h1000, 16'h0000, 16'h7fff, 16'h0000, 16'h7fff);
        drive_directed(16'h0000, 16'h0000, 16'h0000, 16'h1000, 16'h1234, 16'h1234, 16'h2000);
        drive_directed(16'h0001, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'h0001, 16'h0000);
        drive_directed(16'hffff, 16'hffff, 16'h0001, 16'h0001, 16'hc000, 16'h4000, 16'hc000);
        drive_directed(16'h0b50, 16'h0b50, 16'h0000, 16'h0000, 16'h0800, 16'hf800, 16'h0000);
        drive_directed(16'h0800, 16'h0800, 16'h0800, 16'h0800, 16'h2000, 16'h3000, 16'h4000);
        drive_directed(16'h0000, 16'h0000, 16'h0000, 16'h8000, 16'h5555, 16'haaaa, 16'h0fff);
        drive_directed(16'h7fff, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0002, 16'h0003);

        for (int i = 0; i < 180; i++) begin
            if (i % 40 == 0) calm_sender = ($urandom_range(0, 2) == 0);
            if (i % 40 == 20) calm_receiver = ($urandom_range(0, 2) == 0);
            drive_splat(random_splat());
        end
        @(negedge i_clk) i_in_valid <= 1'b0;
        calm_receiver = 0;

        while (sb.expected_axes.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.fails == 0) begin
            $display("gaussian_principal_axes_core_tb: PASS");
        end else begin
            $display("gaussian_principal_axes_core_tb: FAIL");
        end
        $finish;
    end
endmodule
